/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile every check away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/khar_pkg.sv */
// ---------------------------------------------------------------------------
// khar_pkg
// Shared types and constants of the key hold / autorepeat block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package khar_pkg;

  localparam int NUM_BUTTONS  = 32;
  localparam int BTN_BITS     = 32;
  localparam int BTN_LANES    = (NUM_BUTTONS < BTN_BITS) ? NUM_BUTTONS : BTN_BITS;
  localparam int DIR_LANES    = 4;
  localparam int CNT_W        = 16;
  localparam int STEP_W       = $clog2(CNT_W);
  localparam int AXIS_W       = 16;
  localparam int THR_W        = 15;
  localparam int CFG_W        = 16;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 40;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // register reset values
  localparam logic [CFG_W-1:0] DURATION_RST  = 16'hFFFF;
  localparam logic [CFG_W-1:0] DELAY_RST     = 16'hFFFF;
  localparam logic [CFG_W-1:0] INTERVAL_RST  = 16'h0000;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd3200;

  // config register indexes
  typedef enum logic [1:0] {
    REG_HOLD_DURATION   = 2'd0,
    REG_REPEAT_DELAY    = 2'd1,
    REG_REPEAT_INTERVAL = 2'd2,
    REG_AXIS_THRESHOLD  = 2'd3
  } reg_idx_t;

  // direction bit positions
  localparam int DIR_DOWN  = 0;
  localparam int DIR_LEFT  = 1;
  localparam int DIR_RIGHT = 2;
  localparam int DIR_UP    = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  // pulse window timing, two's complement, bit 15 is the sign
  typedef struct packed {
    logic [CFG_W-1:0] duration;
    logic [CFG_W-1:0] delay;
    logic [CFG_W-1:0] interval;
  } timing_cfg_t;

  typedef struct packed {
    logic update;  // advance the hold counter with this tick's level
    logic load;    // evaluate window, seed the remainder unit
    logic step;    // one remainder bit
  } lane_ctrl_t;

endpackage

/* hdl/key_hold_autorepeat_top.sv */
// ---------------------------------------------------------------------------
// key_hold_autorepeat_top
// Typematic qualification of held buttons and stick directions.
// Input word (s_*): one tick of raw button levels and two stick axes.
// Output word (m_*): qualified button and direction states for that tick.
// Config (cfg_*): 0 hold_duration, 1 repeat_delay, 2 repeat_interval,
//   3 axis_threshold; cfg_ready is always high. Write only while idle.
// Each button and direction owns a lane: a hold counter plus a 1-bit/cycle
// remainder unit for the repeat phase. All lanes run in parallel.
// Sequence: accept, load, 16 remainder steps, then the output word register is
//   loaded once it has room, and m_tvalid rises with that load.
//   The next input word is taken only after this result leaves the sequencer.
// A new input word is taken while the previous result still waits.
// If the receiver stalls, the finished result waits in the sequencer until
//   the output register frees up; s_tready stays low meanwhile.
// Reset: counters zero, registers at their reset values, output empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module key_hold_autorepeat_top import khar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: button_levels[31:0], axis_x[47:32], axis_y[63:48]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tdata: pressed_buttons[31:0], pressed_directions[35:32], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  timing_cfg_t       tcfg;
  logic [THR_W-1:0]  threshold;

  seq_state_t        state, state_next;
  logic [STEP_W-1:0] step_cnt;
  lane_ctrl_t        ctrl;
  logic              accept;
  logic              capture;
  logic              room;

  logic [BTN_BITS-1:0]  btn_pressed;
  logic [DIR_LANES-1:0] dir_pressed;
  logic [DIR_LANES-1:0] dir_held;

  logic signed [AXIS_W:0] ax, ay, thr_pos, thr_neg;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tcfg.duration <= DURATION_RST;
      tcfg.delay    <= DELAY_RST;
      tcfg.interval <= INTERVAL_RST;
      threshold     <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HOLD_DURATION:   tcfg.duration <= cfg_data;
        REG_REPEAT_DELAY:    tcfg.delay    <= cfg_data;
        REG_REPEAT_INTERVAL: tcfg.interval <= cfg_data;
        REG_AXIS_THRESHOLD:  threshold     <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // stick directions, strictly beyond the threshold
  always_comb begin
    ax      = {s_tdata[47], s_tdata[47:32]};
    ay      = {s_tdata[63], s_tdata[63:48]};
    thr_pos = {2'b00, threshold};
    thr_neg = -thr_pos;
    dir_held[DIR_DOWN]  = (ay > thr_pos);
    dir_held[DIR_LEFT]  = (ax < thr_neg);
    dir_held[DIR_RIGHT] = (ax > thr_pos);
    dir_held[DIR_UP]    = (ay < thr_neg);
  end

  // sequencer
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) step_cnt <= step_cnt + 1'b1;
      else                 step_cnt <= '0;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    ctrl.update = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    capture     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        ctrl.update = s_tvalid;
        if (s_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.load  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctrl.step = 1'b1;
        if (step_cnt == STEP_W'(CNT_W - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        capture = room;
        if (room) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // button lanes
  for (genvar b = 0; b < BTN_BITS; b++) begin : g_btn
    if (b < BTN_LANES) begin : g_on
      khar_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .tcfg    (tcfg),
        .held    (s_tdata[b]),
        .pressed (btn_pressed[b])
      );
    end else begin : g_off
      assign btn_pressed[b] = 1'b0;
    end
  end

  // direction lanes
  for (genvar d = 0; d < DIR_LANES; d++) begin : g_dir
    khar_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .tcfg    (tcfg),
      .held    (dir_held[d]),
      .pressed (dir_pressed[d])
    );
  end

  khar_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .capture  (capture),
    .btn_bits (btn_pressed),
    .dir_bits (dir_pressed),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `ASSERT_NEXT(a_accept_loads, clk, rst, accept, state == ST_LOAD)
  `ASSERT_IMPLY(a_capture_room, clk, rst, capture, !m_tvalid || m_tready)
  `ASSERT_IMPLY(a_step_idle_zero, clk, rst, state != ST_DIV, step_cnt == '0)
  `ASSERT_NEXT(a_capture_valid, clk, rst, capture, m_tvalid)
  `ASSERT_IMPLY(a_one_ctrl, clk, rst, 1'b1, $onehot0({ctrl.update, ctrl.load, ctrl.step}))

endmodule

/* hdl/khar_lane.sv */
// ---------------------------------------------------------------------------
// khar_lane
// One hold counter with its pulse window and bit-serial repeat phase unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module khar_lane import khar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lane_ctrl_t  ctrl,
  input  timing_cfg_t tcfg,
  input  logic        held,
  output logic        pressed
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] dividend;
  logic [CNT_W-1:0] rem;
  logic             decided;
  logic             fast_on;

  logic             c_zero, d_zero, d_neg, g_neg, v_neg;
  logic             c_le_d, c_le_dg;
  logic [CNT_W:0]   dg;
  logic             dec_now, on_now;
  logic [CNT_W-1:0] divisor;
  logic [CNT_W-1:0] dividend_init;
  logic [CNT_W:0]   trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.update) begin
      if (!held)                  count <= '0;
      else if (count != COUNT_MAX) count <= count + 1'b1;
    end
  end

  always_comb begin
    c_zero  = (count == '0);
    d_zero  = (tcfg.duration == '0);
    d_neg   = tcfg.duration[CFG_W-1];
    g_neg   = tcfg.delay[CFG_W-1];
    v_neg   = tcfg.interval[CFG_W-1];
    c_le_d  = (count <= tcfg.duration);
    dg      = {1'b0, tcfg.duration} + {1'b0, tcfg.delay};
    c_le_dg = ({1'b0, count} <= dg);
    dividend_init = count - dg[CNT_W-1:0] - 1'b1;
    divisor = tcfg.interval + 1'b1;
    dec_now = 1'b1;
    on_now  = 1'b0;
    priority if (c_zero || d_zero) on_now = 1'b0;
    else if (d_neg)                on_now = 1'b1;
    else if (c_le_d)               on_now = 1'b1;
    else if (g_neg)                on_now = 1'b0;
    else if (c_le_dg)              on_now = 1'b0;
    else if (v_neg)                on_now = 1'b0;
    else                           dec_now = 1'b0;  // repeat phase decides
    trial = {rem, dividend[CNT_W-1]};
  end

  // restoring remainder, one dividend bit per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      decided  <= dec_now;
      fast_on  <= on_now;
      dividend <= dividend_init;
      rem      <= '0;
    end else if (ctrl.step) begin
      dividend <= {dividend[CNT_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= CNT_W'(trial - {1'b0, divisor});
      else                          rem <= trial[CNT_W-1:0];
    end
  end

  assign pressed = decided ? fast_on : (rem == '0);

endmodule

/* hdl/khar_merge.sv */
// ---------------------------------------------------------------------------
// khar_merge
// Gathers lane results into the output word register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module khar_merge import khar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  capture,
  input  logic [BTN_BITS-1:0]   btn_bits,
  input  logic [DIR_LANES-1:0]  dir_bits,
  output logic                  room,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int PAD_W = OUT_DATA_W - BTN_BITS - DIR_LANES;

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      m_tdata <= {{PAD_W{1'b0}}, dir_bits, btn_bits};
    end
  end

endmodule
